[rtl/pwb_pkg.sv]
// shared constants, types and codes of the perspective warp block
// used by pwb_div, pwb_store and perspective_warp_bilinear; no dependencies
package pwb_pkg;

	// store geometry
	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 512;
	localparam int COL_W    = 10;
	localparam int ROW_W    = 9;
	localparam int PIX_W    = 8;
	localparam int COLS_W   = 11;
	localparam int ROWS_W   = 10;

	// four banks split by column and row parity
	localparam int NUM_BANKS  = 4;
	localparam int BANK_CW    = COL_W - 1;
	localparam int BANK_RW    = ROW_W - 1;
	localparam int BANK_AW    = BANK_CW + BANK_RW;
	localparam int BANK_DEPTH = 1 << BANK_AW;

	// mapping arithmetic
	localparam int COEF_W = 32;
	localparam int PROD_W = 42;
	localparam int SUM_W  = 44;
	localparam int DEN_W  = 44;
	localparam int NUM_W  = 54;
	localparam int INT_W  = 11;
	localparam int FRAC_W = 11;
	localparam int Q_W    = INT_W + FRAC_W;
	localparam int DIV_LAT = Q_W + 1;

	// blend arithmetic
	localparam int WGT_W  = 12;
	localparam int WP_W   = 23;
	localparam int TERM_W = 31;
	localparam int ACC_W  = 32;
	localparam int BLEND_SHIFT = 22;
	localparam logic [WGT_W-1:0] FRAC_ONE = 12'd2048;

	// edges from accepting edge to the edge that raises done
	localparam int OUT_LAT = DIV_LAT + 6;

	// commands
	localparam logic CMD_WRITE   = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;

	// register indexes
	localparam logic [2:0] CFG_A     = 3'd0;
	localparam logic [2:0] CFG_B     = 3'd1;
	localparam logic [2:0] CFG_C     = 3'd2;
	localparam logic [2:0] CFG_PERSP = 3'd3;
	localparam logic [2:0] CFG_SCALE = 3'd4;
	localparam logic [2:0] CFG_COLS  = 3'd5;
	localparam logic [2:0] CFG_ROWS  = 3'd6;

	typedef struct packed {
		logic             valid;
		logic             cmd;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [PIX_W-1:0] val;
		logic             ok;
	} side_t;

	typedef struct packed {
		logic                                 we;
		logic [1:0]                           wbank;
		logic [BANK_AW-1:0]                   waddr;
		logic [PIX_W-1:0]                     wdata;
		logic [NUM_BANKS-1:0][BANK_AW-1:0]    raddr;
	} store_req_t;

endpackage

[rtl/pwb_div.sv]
// pipelined restoring divider: 11 integer and 11 fraction quotient bits
// depends on pwb_pkg
module pwb_div (
	input  logic                        clk,
	input  logic [pwb_pkg::NUM_W-1:0]   num,
	input  logic [pwb_pkg::DEN_W-1:0]   den,
	output logic [pwb_pkg::Q_W-1:0]     quot,
	output logic                        exact,
	output logic                        ovf
);

	logic [pwb_pkg::DEN_W-1:0] rem_s  [0:pwb_pkg::Q_W-1];
	logic [pwb_pkg::DEN_W-1:0] d_s    [0:pwb_pkg::Q_W-1];
	logic [pwb_pkg::INT_W-1:0] lo_s   [0:pwb_pkg::Q_W-1];
	logic [pwb_pkg::Q_W-1:0]   q_s    [0:pwb_pkg::Q_W];
	logic                      ovf_s  [0:pwb_pkg::Q_W];
	logic                      exact_s[0:pwb_pkg::Q_W];

	logic [pwb_pkg::DEN_W:0]   t_c    [0:pwb_pkg::Q_W-1];
	logic [pwb_pkg::DEN_W-1:0] rem_nx [0:pwb_pkg::Q_W-1];
	logic                      take_c [0:pwb_pkg::Q_W-1];
	logic [pwb_pkg::DEN_W-1:0] hi_c;

	// upper dividend bits start the remainder; quotient fits 11 bits only if they stay below den
	assign hi_c = pwb_pkg::DEN_W'(num[pwb_pkg::NUM_W-1:pwb_pkg::INT_W]);

	always_comb begin
		for (int k = 0; k < pwb_pkg::Q_W; k++) begin
			t_c[k]    = {rem_s[k], lo_s[k][pwb_pkg::INT_W-1]};
			take_c[k] = (t_c[k] >= {1'b0, d_s[k]});
			rem_nx[k] = take_c[k] ? pwb_pkg::DEN_W'(t_c[k] - {1'b0, d_s[k]})
			                      : t_c[k][pwb_pkg::DEN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]   <= hi_c;
		d_s[0]     <= den;
		lo_s[0]    <= num[pwb_pkg::INT_W-1:0];
		q_s[0]     <= '0;
		ovf_s[0]   <= (hi_c >= den);
		exact_s[0] <= 1'b0;
		for (int k = 0; k < pwb_pkg::Q_W; k++) begin
			if (k < pwb_pkg::Q_W - 1) begin
				rem_s[k+1] <= rem_nx[k];
				d_s[k+1]   <= d_s[k];
				lo_s[k+1]  <= {lo_s[k][pwb_pkg::INT_W-2:0], 1'b0};
			end
			q_s[k+1]     <= {q_s[k][pwb_pkg::Q_W-2:0], take_c[k]};
			ovf_s[k+1]   <= ovf_s[k];
			// zero remainder once the integer bits are done
			exact_s[k+1] <= (k == pwb_pkg::INT_W - 1) ? (rem_nx[k] == '0) : exact_s[k];
		end
	end

	assign quot  = q_s[pwb_pkg::Q_W];
	assign exact = exact_s[pwb_pkg::Q_W];
	assign ovf   = ovf_s[pwb_pkg::Q_W];

endmodule

[rtl/pwb_store.sv]
// source image store: four parity banks, one write and one read per bank per cycle
// depends on pwb_pkg
module pwb_store (
	input  logic                                               clk,
	input  pwb_pkg::store_req_t                                req,
	output logic [pwb_pkg::NUM_BANKS-1:0][pwb_pkg::PIX_W-1:0]  rdata
);

	for (genvar b = 0; b < pwb_pkg::NUM_BANKS; b++) begin : g_bank
		logic [pwb_pkg::PIX_W-1:0] mem [0:pwb_pkg::BANK_DEPTH-1];
		logic [pwb_pkg::PIX_W-1:0] rdata_q;

		always_ff @(posedge clk) begin
			if (req.we && req.wbank == 2'(b)) begin
				mem[req.waddr] <= req.wdata;
			end
			rdata_q <= mem[req.raddr[b]];
		end

		assign rdata[b] = rdata_q;
	end

endmodule

[rtl/perspective_warp_bilinear.sv]
// perspective warp with bilinear blend; uses pwb_pkg, pwb_div, pwb_store
// one word (write or query) accepted every cycle; busy only drops once after reset
// done rises for one cycle per accepted query, as the query leaves the pipeline; no stall
// the pipeline is the 22-step pipelined quotient plus map, read and blend stages
// async reset sets the configuration registers to defaults and clears pipeline valids; store contents stay undefined
module perspective_warp_bilinear (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [9:0]  pix_col,
	input  logic [8:0]  pix_row,
	input  logic [7:0]  pix_value,
	output logic        done,
	output logic [9:0]  out_col,
	output logic [8:0]  out_row,
	output logic [7:0]  warped_pixel,
	output logic        inside_mask,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	// ---------------- configuration registers ----------------
	logic        ready_q;
	logic [63:0] coef_a_q, coef_b_q, coef_c_q, coef_persp_q;
	logic [31:0] coef_scale_q;
	logic [pwb_pkg::COLS_W-1:0] image_cols_q;
	logic [pwb_pkg::ROWS_W-1:0] image_rows_q;

	assign busy      = !ready_q;
	assign cfg_ready = ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q      <= 1'b0;
			coef_a_q     <= 64'h0010_0000_0000_0000;
			coef_b_q     <= '0;
			coef_c_q     <= 64'h0010_0000_0000_0000;
			coef_persp_q <= '0;
			coef_scale_q <= 32'h0010_0000;
			image_cols_q <= 11'd640;
			image_rows_q <= 10'd480;
		end else begin
			ready_q <= 1'b1;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pwb_pkg::CFG_A:     coef_a_q     <= cfg_data;
					pwb_pkg::CFG_B:     coef_b_q     <= cfg_data;
					pwb_pkg::CFG_C:     coef_c_q     <= cfg_data;
					pwb_pkg::CFG_PERSP: coef_persp_q <= cfg_data;
					pwb_pkg::CFG_SCALE: coef_scale_q <= cfg_data[31:0];
					pwb_pkg::CFG_COLS:  image_cols_q <= cfg_data[pwb_pkg::COLS_W-1:0];
					pwb_pkg::CFG_ROWS:  image_rows_q <= cfg_data[pwb_pkg::ROWS_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// homography terms
	logic signed [31:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
	assign h00 = coef_a_q[63:32];
	assign h01 = coef_a_q[31:0];
	assign h02 = coef_b_q[63:32];
	assign h10 = coef_b_q[31:0];
	assign h11 = coef_c_q[63:32];
	assign h12 = coef_c_q[31:0];
	assign h20 = coef_persp_q[63:32];
	assign h21 = coef_persp_q[31:0];
	assign h22 = coef_scale_q;

	// image size clamped to the store
	logic [pwb_pkg::COLS_W-1:0] cols_c, cols_lim;
	logic [pwb_pkg::ROWS_W-1:0] rows_c;
	logic [pwb_pkg::INT_W-1:0]  rows_lim, rows_ext;

	assign cols_c   = (image_cols_q > pwb_pkg::COLS_W'(pwb_pkg::MAX_COLS))
	                ? pwb_pkg::COLS_W'(pwb_pkg::MAX_COLS) : image_cols_q;
	assign rows_c   = (image_rows_q > pwb_pkg::ROWS_W'(pwb_pkg::MAX_ROWS))
	                ? pwb_pkg::ROWS_W'(pwb_pkg::MAX_ROWS) : image_rows_q;
	assign cols_lim = cols_c - 1'b1;
	assign rows_ext = pwb_pkg::INT_W'(rows_c);
	assign rows_lim = rows_ext - 1'b1;

	// ---------------- stage 1: products ----------------
	logic accept;
	logic signed [10:0] xs, ys;
	pwb_pkg::side_t side_s1, side_s2, side_s3, side_in;
	logic signed [pwb_pkg::PROD_W-1:0] p00x_s1, p01y_s1, p10x_s1, p11y_s1, p20x_s1, p21y_s1;

	assign accept = start && !busy;
	assign xs = {1'b0, pix_col};
	assign ys = {2'b00, pix_row};

	always_ff @(posedge clk) begin
		p00x_s1 <= h00 * xs;
		p01y_s1 <= h01 * ys;
		p10x_s1 <= h10 * xs;
		p11y_s1 <= h11 * ys;
		p20x_s1 <= h20 * xs;
		p21y_s1 <= h21 * ys;
	end

	// ---------------- stage 2: numerators and denominator ----------------
	logic signed [pwb_pkg::SUM_W-1:0] nx_s2, ny_s2, den_s2;

	always_ff @(posedge clk) begin
		nx_s2  <= pwb_pkg::SUM_W'(p00x_s1) + pwb_pkg::SUM_W'(p01y_s1) + pwb_pkg::SUM_W'(h02);
		ny_s2  <= pwb_pkg::SUM_W'(p10x_s1) + pwb_pkg::SUM_W'(p11y_s1) + pwb_pkg::SUM_W'(h12);
		den_s2 <= pwb_pkg::SUM_W'(p20x_s1) + pwb_pkg::SUM_W'(p21y_s1)
		        + (pwb_pkg::SUM_W'(h22) <<< 10);
	end

	// ---------------- stage 3: make the denominator positive ----------------
	logic signed [pwb_pkg::SUM_W:0] nx_s3, ny_s3, den_s3;
	logic zero_s3;

	always_ff @(posedge clk) begin
		zero_s3 <= (den_s2 == '0);
		if (den_s2[pwb_pkg::SUM_W-1]) begin
			nx_s3  <= -((pwb_pkg::SUM_W+1)'(nx_s2));
			ny_s3  <= -((pwb_pkg::SUM_W+1)'(ny_s2));
			den_s3 <= -((pwb_pkg::SUM_W+1)'(den_s2));
		end else begin
			nx_s3  <= (pwb_pkg::SUM_W+1)'(nx_s2);
			ny_s3  <= (pwb_pkg::SUM_W+1)'(ny_s2);
			den_s3 <= (pwb_pkg::SUM_W+1)'(den_s2);
		end
	end

	// pipeline valid bits and item fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
		end else begin
			side_s1 <= '{valid: accept, cmd: command, col: pix_col, row: pix_row,
			             val: pix_value, ok: 1'b0};
			side_s2 <= side_s1;
			side_s3 <= side_s2;
		end
	end

	// early outside cases: zero denominator, empty image, negative numerator
	always_comb begin
		side_in    = side_s3;
		side_in.ok = !zero_s3 && (cols_c != '0) && (rows_c != '0)
		          && !nx_s3[pwb_pkg::SUM_W] && !ny_s3[pwb_pkg::SUM_W];
	end

	// ---------------- stages 4..26: two quotient pipelines ----------------
	logic [pwb_pkg::Q_W-1:0] qx, qy;
	logic exx, exy, ovx, ovy;

	pwb_div u_div_x (
		.clk   (clk),
		.num   ({nx_s3[pwb_pkg::DEN_W-1:0], 10'b0}),
		.den   (den_s3[pwb_pkg::DEN_W-1:0]),
		.quot  (qx),
		.exact (exx),
		.ovf   (ovx)
	);

	pwb_div u_div_y (
		.clk   (clk),
		.num   ({ny_s3[pwb_pkg::DEN_W-1:0], 10'b0}),
		.den   (den_s3[pwb_pkg::DEN_W-1:0]),
		.quot  (qy),
		.exact (exy),
		.ovf   (ovy)
	);

	pwb_pkg::side_t side_div_s [0:pwb_pkg::DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < pwb_pkg::DIV_LAT; k++) begin
				side_div_s[k] <= '0;
			end
		end else begin
			side_div_s[0] <= side_in;
			for (int k = 1; k < pwb_pkg::DIV_LAT; k++) begin
				side_div_s[k] <= side_div_s[k-1];
			end
		end
	end

	// ---------------- stage 27: inside test, weights, neighbor limits ----------------
	pwb_pkg::side_t side_s27, side_s28, side_s29, side_dv;
	logic [pwb_pkg::INT_W-1:0] ix, iy;
	logic in_x, in_y, in_img;
	logic in_img_s27, nbx_s27, nby_s27;
	logic [pwb_pkg::COL_W-1:0]  ix_s27;
	logic [pwb_pkg::ROW_W-1:0]  iy_s27;
	logic [pwb_pkg::FRAC_W-1:0] fx_s27, fy_s27;

	assign side_dv = side_div_s[pwb_pkg::DIV_LAT-1];
	assign ix = qx[pwb_pkg::Q_W-1:pwb_pkg::FRAC_W];
	assign iy = qy[pwb_pkg::Q_W-1:pwb_pkg::FRAC_W];
	// last column or row counts only when it is hit exactly
	assign in_x   = (ix < cols_lim) || ((ix == cols_lim) && exx);
	assign in_y   = (iy < rows_lim) || ((iy == rows_lim) && exy);
	assign in_img = side_dv.ok && !ovx && !ovy && in_x && in_y;

	always_ff @(posedge clk) begin
		in_img_s27 <= in_img;
		ix_s27     <= ix[pwb_pkg::COL_W-1:0];
		iy_s27     <= iy[pwb_pkg::ROW_W-1:0];
		fx_s27     <= qx[pwb_pkg::FRAC_W-1:0];
		fy_s27     <= qy[pwb_pkg::FRAC_W-1:0];
		// right and lower neighbors past the edge read as zero
		nbx_s27    <= (ix + 1'b1) < cols_c;
		nby_s27    <= (iy + 1'b1) < rows_ext;
	end

	// ---------------- store access from stage 27 ----------------
	pwb_pkg::store_req_t req;
	logic [pwb_pkg::NUM_BANKS-1:0][pwb_pkg::PIX_W-1:0] rdata;
	logic [pwb_pkg::BANK_CW-1:0] ch_even, ch_odd;
	logic [pwb_pkg::BANK_RW-1:0] rh_even, rh_odd;

	// the even neighbor sits one bank word further when the base is odd
	assign ch_odd  = ix_s27[pwb_pkg::COL_W-1:1];
	assign ch_even = ix_s27[0] ? ch_odd + 1'b1 : ch_odd;
	assign rh_odd  = iy_s27[pwb_pkg::ROW_W-1:1];
	assign rh_even = iy_s27[0] ? rh_odd + 1'b1 : rh_odd;

	always_comb begin
		req.we    = side_s27.valid && (side_s27.cmd == pwb_pkg::CMD_WRITE);
		req.wbank = {side_s27.row[0], side_s27.col[0]};
		req.waddr = {side_s27.row[pwb_pkg::ROW_W-1:1], side_s27.col[pwb_pkg::COL_W-1:1]};
		req.wdata = side_s27.val;
		for (int b = 0; b < pwb_pkg::NUM_BANKS; b++) begin
			req.raddr[b] = {(b >= 2) ? rh_odd : rh_even, b[0] ? ch_odd : ch_even};
		end
	end

	pwb_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	// ---------------- stage 28: weight products, read data arrives ----------------
	logic [pwb_pkg::WGT_W-1:0] fxw, fyw, gxw, gyw;
	logic [pwb_pkg::WP_W-1:0]  w00_s28, w10_s28, w01_s28, w11_s28;
	logic xs_s28, ys_s28, nbx_s28, nby_s28, in_img_s28;

	assign fxw = pwb_pkg::WGT_W'(fx_s27);
	assign fyw = pwb_pkg::WGT_W'(fy_s27);
	assign gxw = pwb_pkg::FRAC_ONE - fxw;
	assign gyw = pwb_pkg::FRAC_ONE - fyw;

	always_ff @(posedge clk) begin
		w00_s28    <= gxw * gyw;
		w10_s28    <= fxw * gyw;
		w01_s28    <= gxw * fyw;
		w11_s28    <= fxw * fyw;
		xs_s28     <= ix_s27[0];
		ys_s28     <= iy_s27[0];
		nbx_s28    <= nbx_s27;
		nby_s28    <= nby_s27;
		in_img_s28 <= in_img_s27;
	end

	// ---------------- stage 29: pick banks, weight the pixels ----------------
	logic [pwb_pkg::PIX_W-1:0]  px00, px10, px01, px11;
	logic [pwb_pkg::TERM_W-1:0] t00_s29, t10_s29, t01_s29, t11_s29;
	logic in_img_s29;

	assign px00 = rdata[{ys_s28, xs_s28}];
	assign px10 = nbx_s28 ? rdata[{ys_s28, !xs_s28}] : '0;
	assign px01 = nby_s28 ? rdata[{!ys_s28, xs_s28}] : '0;
	assign px11 = (nbx_s28 && nby_s28) ? rdata[{!ys_s28, !xs_s28}] : '0;

	always_ff @(posedge clk) begin
		t00_s29    <= w00_s28 * px00;
		t10_s29    <= w10_s28 * px10;
		t01_s29    <= w01_s28 * px01;
		t11_s29    <= w11_s28 * px11;
		in_img_s29 <= in_img_s28;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s27 <= '0;
			side_s28 <= '0;
			side_s29 <= '0;
		end else begin
			side_s27 <= side_dv;
			side_s28 <= side_s27;
			side_s29 <= side_s28;
		end
	end

	// ---------------- output registers ----------------
	logic [pwb_pkg::ACC_W-1:0] acc;
	logic       done_q, inside_mask_q;
	logic [9:0] out_col_q;
	logic [8:0] out_row_q;
	logic [7:0] warped_pixel_q;

	// weights sum to 2^22, so the blend stays below 2^30
	assign acc = pwb_pkg::ACC_W'(t00_s29) + pwb_pkg::ACC_W'(t10_s29)
	           + pwb_pkg::ACC_W'(t01_s29) + pwb_pkg::ACC_W'(t11_s29);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= side_s29.valid && (side_s29.cmd == pwb_pkg::CMD_COMPUTE);
		end
	end

	always_ff @(posedge clk) begin
		out_col_q      <= side_s29.col;
		out_row_q      <= side_s29.row;
		inside_mask_q  <= in_img_s29;
		warped_pixel_q <= in_img_s29 ? acc[pwb_pkg::BLEND_SHIFT +: pwb_pkg::PIX_W] : '0;
	end

	assign done         = done_q;
	assign out_col      = out_col_q;
	assign out_row      = out_row_q;
	assign warped_pixel = warped_pixel_q;
	assign inside_mask  = inside_mask_q;

	// ---------------- assertions ----------------
	// done is sampled high at the edge after the one that raises it
	a_done_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && command == pwb_pkg::CMD_COMPUTE, pwb_pkg::OUT_LAT + 1))
		else $error("done without a query accepted at the pipeline depth");

	a_done_col: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> out_col == $past(pix_col, pwb_pkg::OUT_LAT + 1))
		else $error("result column does not match its query");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !inside_mask |-> warped_pixel == '0)
		else $error("outside point gave a nonzero pixel");

endmodule

[sim/perspective_warp_bilinear_tb.sv]
// self-checking testbench of the perspective warp block: scoreboard class plus drive tasks
// depends on rtl/pwb_pkg.sv and rtl/perspective_warp_bilinear.sv
`timescale 1ns / 1ps

module perspective_warp_bilinear_tb;

	// one result word as the block presents it
	typedef struct {
		bit [pwb_pkg::COL_W-1:0] col;
		bit [pwb_pkg::ROW_W-1:0] row;
		bit [pwb_pkg::PIX_W-1:0] pix;
		bit                      mask;
	} warp_word_t;

	// mirror of the block: coefficient registers, source image and pending results
	class warp_scoreboard;
		bit [7:0]   pixels [pwb_pkg::MAX_COLS*pwb_pkg::MAX_ROWS];
		bit [63:0]  regs [8];
		longint     cols_used, rows_used;
		// base neighbor of the last mapped query, valid when it lands inside
		bit         last_in;
		longint     last_ix, last_iy;
		warp_word_t pending_q [$];
		int         errors;

		function new();
			regs[pwb_pkg::CFG_A]     = 64'd4503599627370496;
			regs[pwb_pkg::CFG_B]     = 64'd0;
			regs[pwb_pkg::CFG_C]     = 64'd4503599627370496;
			regs[pwb_pkg::CFG_PERSP] = 64'd0;
			regs[pwb_pkg::CFG_SCALE] = 64'd1048576;
			regs[pwb_pkg::CFG_COLS]  = 64'd640;
			regs[pwb_pkg::CFG_ROWS]  = 64'd480;
			last_in = 1'b0;
			errors = 0;
		endfunction

		function void set_reg(bit [2:0] idx, bit [63:0] data);
			// indexes past the register list are dropped by the block
			if (idx <= pwb_pkg::CFG_ROWS)
				regs[idx] = data;
		endfunction

		function longint sx(bit [31:0] v);
			return longint'(signed'(v));
		endfunction

		function longint fetch(longint c, longint r);
			if (c < 0 || r < 0 || c >= cols_used || r >= rows_used)
				return 0;
			return longint'(pixels[r * pwb_pkg::MAX_COLS + c]);
		endfunction

		// integer part and 11-bit fraction of num(q20) / den(q30)
		function void split(longint num, longint den, output longint ip, output longint fr);
			longint unsigned n, d, r;
			n = longint'(num) << 10;
			d = den;
			ip = n / d;
			r = n % d;
			fr = (r << pwb_pkg::FRAC_W) / d;
		endfunction

		function warp_word_t map_pixel(bit [pwb_pkg::COL_W-1:0] col,
				bit [pwb_pkg::ROW_W-1:0] row);
			warp_word_t res;
			longint x, y, nx, ny, den, ix, iy, fx, fy, gx, gy, acc;
			last_in = 1'b0;
			x = longint'(col);
			y = longint'(row);
			cols_used = longint'(regs[pwb_pkg::CFG_COLS][10:0]);
			rows_used = longint'(regs[pwb_pkg::CFG_ROWS][9:0]);
			if (cols_used > pwb_pkg::MAX_COLS) cols_used = pwb_pkg::MAX_COLS;
			if (rows_used > pwb_pkg::MAX_ROWS) rows_used = pwb_pkg::MAX_ROWS;
			nx = sx(regs[pwb_pkg::CFG_A][63:32]) * x + sx(regs[pwb_pkg::CFG_A][31:0]) * y
				+ sx(regs[pwb_pkg::CFG_B][63:32]);
			ny = sx(regs[pwb_pkg::CFG_B][31:0]) * x + sx(regs[pwb_pkg::CFG_C][63:32]) * y
				+ sx(regs[pwb_pkg::CFG_C][31:0]);
			den = sx(regs[pwb_pkg::CFG_PERSP][63:32]) * x + sx(regs[pwb_pkg::CFG_PERSP][31:0]) * y
				+ sx(regs[pwb_pkg::CFG_SCALE][31:0]) * 1024;
			res.col = col;
			res.row = row;
			res.pix = 0;
			res.mask = 0;
			if (den == 0 || cols_used == 0 || rows_used == 0)
				return res;
			if (den < 0) begin
				den = -den;
				nx = -nx;
				ny = -ny;
			end
			if (nx < 0 || ny < 0 || nx * 1024 > (cols_used - 1) * den
					|| ny * 1024 > (rows_used - 1) * den)
				return res;
			split(nx, den, ix, fx);
			split(ny, den, iy, fy);
			last_in = 1'b1;
			last_ix = ix;
			last_iy = iy;
			gx = 2048 - fx;
			gy = 2048 - fy;
			acc = gx * gy * fetch(ix, iy) + fx * gy * fetch(ix + 1, iy)
				+ gx * fy * fetch(ix, iy + 1) + fx * fy * fetch(ix + 1, iy + 1);
			res.pix = 8'((acc >> pwb_pkg::BLEND_SHIFT) & 255);
			res.mask = 1;
			return res;
		endfunction

		function void note(bit cmd, bit [pwb_pkg::COL_W-1:0] col, bit [pwb_pkg::ROW_W-1:0] row,
				bit [7:0] val);
			if (cmd == pwb_pkg::CMD_WRITE)
				pixels[int'(row) * pwb_pkg::MAX_COLS + int'(col)] = val;
			else
				pending_q.insert(pending_q.size(), map_pixel(col, row));
		endfunction

		function void check(bit [pwb_pkg::COL_W-1:0] col, bit [pwb_pkg::ROW_W-1:0] row,
				bit [7:0] pix, bit mask);
			warp_word_t exp_w;
			if (pending_q.size() == 0) begin
				$display("%0t: result with nothing pending: col %0d row %0d pix %0d mask %0d",
					$time, col, row, pix, mask);
				errors++;
				return;
			end
			exp_w = pending_q[0];
			pending_q.delete(0);
			if (exp_w.col != col) begin
				$display("%0t: out_col expected %0d actual %0d", $time, exp_w.col, col);
				errors++;
			end
			if (exp_w.row != row) begin
				$display("%0t: out_row expected %0d actual %0d", $time, exp_w.row, row);
				errors++;
			end
			if (exp_w.pix != pix) begin
				$display("%0t: warped_pixel expected %0d actual %0d", $time, exp_w.pix, pix);
				errors++;
			end
			if (exp_w.mask != mask) begin
				$display("%0t: inside_mask expected %0d actual %0d", $time, exp_w.mask, mask);
				errors++;
			end
		endfunction

		function int pending();
			return pending_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        command = pwb_pkg::CMD_WRITE;
	logic [9:0]  pix_col = '0;
	logic [8:0]  pix_row = '0;
	logic [7:0]  pix_value = '0;
	logic        done;
	logic [9:0]  out_col;
	logic [8:0]  out_row;
	logic [7:0]  warped_pixel;
	logic        inside_mask;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = pwb_pkg::CFG_A;
	logic [63:0] cfg_data = '0;

	// store bytes already sent to the block
	bit filled [pwb_pkg::MAX_COLS*pwb_pkg::MAX_ROWS];

	warp_scoreboard sb = new();

	perspective_warp_bilinear dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .pix_col(pix_col), .pix_row(pix_row), .pix_value(pix_value),
		.done(done), .out_col(out_col), .out_row(out_row),
		.warped_pixel(warped_pixel), .inside_mask(inside_mask),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// watch both sides at every edge; values read here are the ones before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note(command, pix_col, pix_row, pix_value);
			if (done)
				sb.check(out_col, out_row, warped_pixel, inside_mask);
		end
	end

	// one word to the block, then now and then a random idle stretch
	task send_word(bit cmd, bit [9:0] c, bit [8:0] r, bit [7:0] v, int idle_pct);
		if (cmd == pwb_pkg::CMD_WRITE)
			filled[int'(r) * pwb_pkg::MAX_COLS + int'(c)] = 1'b1;
		start <= 1'b1;
		command <= cmd;
		pix_col <= c;
		pix_row <= r;
		pix_value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	// write every store byte the query will read that was never written, then send it
	task query(bit [9:0] c, bit [8:0] r, int idle_pct);
		bit     hit;
		longint bx, by, cc, rr, lc, lr;
		void'(sb.map_pixel(c, r));
		hit = sb.last_in;
		bx = sb.last_ix;
		by = sb.last_iy;
		lc = sb.cols_used;
		lr = sb.rows_used;
		if (hit) begin
			for (int dy = 0; dy < 2; dy++)
				for (int dx = 0; dx < 2; dx++) begin
					cc = bx + dx;
					rr = by + dy;
					if (cc < lc && rr < lr && !filled[rr * pwb_pkg::MAX_COLS + cc])
						send_word(pwb_pkg::CMD_WRITE, 10'(cc), 9'(rr), 8'($urandom), idle_pct);
				end
		end
		send_word(pwb_pkg::CMD_COMPUTE, c, r, 8'($urandom), idle_pct);
	endtask

	// let every pending result come out, then give writes in flight time to land
	task drain();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (pwb_pkg::OUT_LAT + 4) @(posedge clk);
	endtask

	task write_reg(bit [2:0] idx, bit [63:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, data);
	endtask

	function automatic bit [31:0] spread(int center, int span);
		return 32'(center + int'($urandom_range(0, 2 * span)) - span);
	endfunction

	task identity(bit [10:0] cols, bit [9:0] rows);
		write_reg(pwb_pkg::CFG_A, {32'h0010_0000, 32'h0});
		write_reg(pwb_pkg::CFG_B, 64'h0);
		write_reg(pwb_pkg::CFG_C, {32'h0010_0000, 32'h0});
		write_reg(pwb_pkg::CFG_PERSP, 64'h0);
		write_reg(pwb_pkg::CFG_SCALE, 64'h0010_0000);
		write_reg(pwb_pkg::CFG_COLS, {53'h0, cols});
		write_reg(pwb_pkg::CFG_ROWS, {54'h0, rows});
	endtask

	// mild random homography; now and then a register takes any value at all
	task random_map(output int cols, output int rows);
		cols = ($urandom_range(7) == 0) ? 1024 : $urandom_range(2, 1024);
		rows = ($urandom_range(7) == 0) ? 512 : $urandom_range(2, 512);
		write_reg(pwb_pkg::CFG_A, {spread(1 << 20, 1 << 20), spread(0, 1 << 18)});
		write_reg(pwb_pkg::CFG_B, {spread(0, cols << 18), spread(0, 1 << 18)});
		write_reg(pwb_pkg::CFG_C, {spread(1 << 20, 1 << 20), spread(0, rows << 18)});
		write_reg(pwb_pkg::CFG_PERSP, {spread(0, 1 << 17), spread(0, 1 << 17)});
		write_reg(pwb_pkg::CFG_SCALE, {32'h0,
			spread(($urandom_range(5) == 0) ? -(1 << 20) : (1 << 20), 1 << 18)});
		if ($urandom_range(9) == 0)
			write_reg(3'($urandom_range(pwb_pkg::CFG_A, pwb_pkg::CFG_SCALE)),
				{$urandom, $urandom});
		write_reg(pwb_pkg::CFG_COLS, {$urandom, 21'h0, cols[10:0]} & 64'h7FF);
		write_reg(pwb_pkg::CFG_ROWS, {54'h0, rows[9:0]});
	endtask

	initial begin
		int idle_list [4] = '{0, 72, 0, 19};
		int cols, rows, idle_pct;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset mapping at the corners and past the image
		query(0, 0, 0);
		query(639, 479, 0);
		query(1023, 511, 0);
		query(700, 100, 0);

		// fractional blend between a black and a white neighbor
		send_word(pwb_pkg::CMD_WRITE, 5, 5, 8'h00, 0);
		send_word(pwb_pkg::CMD_WRITE, 6, 5, 8'hFF, 0);
		write_reg(pwb_pkg::CFG_A, {32'h0014_0000, 32'h0004_0000});
		write_reg(pwb_pkg::CFG_B, {32'h0008_0000, 32'h0002_0000});
		write_reg(pwb_pkg::CFG_C, {32'h0010_0000, 32'h0000_4000});
		query(3, 5, 0);
		query(4, 4, 0);

		// negative denominator with mirrored numerators maps back inside
		write_reg(pwb_pkg::CFG_A, {-32'sd1048576, 32'h0});
		write_reg(pwb_pkg::CFG_B, 64'h0);
		write_reg(pwb_pkg::CFG_C, {-32'sd1048576, 32'h0});
		write_reg(pwb_pkg::CFG_SCALE, {32'h0, -32'sd1048576});
		query(3, 4, 0);

		// zero denominator is outside
		write_reg(pwb_pkg::CFG_SCALE, 64'h0);
		query(10, 10, 0);

		// oversized size registers clamp; last column and row reach a zero-weight edge
		identity(11'h7FF, 10'h3FF);
		query(1023, 511, 0);
		query(1023, 0, 0);

		// size zero makes everything outside; unknown index is dropped
		write_reg(pwb_pkg::CFG_COLS, 64'h0);
		write_reg(3'd7, '1);
		query(1, 1, 0);

		// every register at all ones
		for (int i = pwb_pkg::CFG_A; i <= pwb_pkg::CFG_ROWS; i++)
			write_reg(3'(i), '1);
		query(0, 0, 0);
		query(512, 256, 0);

		// random phases: mostly queries over the image in use, some writes and stray queries
		for (int ph = 0; ph < 8; ph++) begin
			idle_pct = idle_list[ph % 4];
			if (ph == 0) begin
				identity(1024, 512);
				cols = 1024;
				rows = 512;
			end else
				random_map(cols, rows);
			for (int n = 0; n < 80; n++) begin
				if ($urandom_range(9) < 3)
					send_word(pwb_pkg::CMD_WRITE, 10'($urandom), 9'($urandom), 8'($urandom),
						idle_pct);
				else if ($urandom_range(9) == 0)
					query(10'($urandom), 9'($urandom), idle_pct);
				else
					query(10'($urandom_range(0, cols - 1)), 9'($urandom_range(0, rows - 1)),
						idle_pct);
			end
		end

		drain();
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// generous ceiling on the length of a full run
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

[filelist.f]
rtl/pwb_pkg.sv
rtl/pwb_div.sv
rtl/pwb_store.sv
rtl/perspective_warp_bilinear.sv
sim/perspective_warp_bilinear_tb.sv
